/* design/lsch_pkg.sv */
// -----------------------------------------------------------------------------
// Lottery scheduler package
// Shared sizes, command and status codes, sequencer states and ticket helpers.
// -----------------------------------------------------------------------------
package lsch_pkg;

  // table geometry
  localparam int SLOTS      = 16;
  localparam int TICKET_CAP = 30;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TICKET_W   = $clog2(TICKET_CAP + 1);
  localparam int TOTAL_W    = $clog2(SLOTS * TICKET_CAP + 1);

  // item field widths
  localparam int CMD_W         = 2;
  localparam int SLOT_FIELD_W  = 4;
  localparam int DRAW_W        = 16;
  localparam int STATUS_W      = 2;
  localparam int TOTAL_FIELD_W = 9;
  localparam int TOTAL_FIELD_MAX = (1 << TOTAL_FIELD_W) - 1;
  localparam int DIV_CNT_W     = $clog2(DRAW_W + 1);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  // start ticket counts, limited to the cap
  localparam int START_SYS_TICKETS = (10 > TICKET_CAP) ? TICKET_CAP : 10;
  localparam int START_INH_TICKETS = (5 > TICKET_CAP) ? TICKET_CAP : 5;

  typedef logic [TICKET_W-1:0] ticket_t;
  typedef logic [TOTAL_W-1:0]  total_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_START_SYS = 2'd0,
    CMD_START_INH = 2'd1,
    CMD_STOP      = 2'd2,
    CMD_EXPIRE    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_INACTIVE   = 2'd1,
    ST_NO_TICKETS = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DYNAMIC   = 2'd0,
    CFG_ALTERNATE = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_SUM,
    S_MOD,
    S_DRAW,
    S_OUT
  } state_e;

  // loser reward: one ticket, or two in alternate mode, never past the cap
  function automatic ticket_t grow_loser(input ticket_t t, input logic alt);
    ticket_t v;
    v = t;
    if (v < ticket_t'(TICKET_CAP)) begin
      v = ticket_t'(v + 1'b1);
      if (alt && (v < ticket_t'(TICKET_CAP))) begin
        v = ticket_t'(v + 1'b1);
      end
    end
    return v;
  endfunction

  // reported total saturates at the field maximum
  function automatic logic [TOTAL_FIELD_W-1:0] sat_total(input total_t t);
    logic [TOTAL_FIELD_W-1:0] r;
    if (32'(t) > TOTAL_FIELD_MAX) begin
      r = TOTAL_FIELD_W'(TOTAL_FIELD_MAX);
    end else begin
      r = TOTAL_FIELD_W'(t);
    end
    return r;
  endfunction

endpackage

/* design/lsch_if.sv */
// -----------------------------------------------------------------------------
// Lottery scheduler channels
// Command, result and configuration channels with valid/ready handshakes.
// -----------------------------------------------------------------------------

// command item channel
interface lsch_in_if import lsch_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [SLOT_FIELD_W-1:0] slot;
  logic [DRAW_W-1:0]       draw_value;

  modport source (output valid, output cmd, output slot, output draw_value, input ready);
  modport sink   (input valid, input cmd, input slot, input draw_value, output ready);
endinterface

// result item channel
interface lsch_out_if import lsch_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic                     winner_valid;
  logic [SLOT_FIELD_W-1:0]  winner_slot;
  logic [TOTAL_FIELD_W-1:0] total_tickets;

  modport source (output valid, output status, output winner_valid, output winner_slot,
                  output total_tickets, input ready);
  modport sink   (input valid, input status, input winner_valid, input winner_slot,
                  input total_tickets, output ready);
endinterface

// register write channel
interface lsch_cfg_if import lsch_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/lsch_mod.sv */
// -----------------------------------------------------------------------------
// Lottery scheduler modulo unit
// Restoring division, one quotient bit per cycle; returns the remainder.
// -----------------------------------------------------------------------------
module lsch_mod import lsch_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DRAW_W-1:0] dividend_i,
  input  total_t            divisor_i,
  output logic              done_o,
  output total_t            rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DRAW_W-1:0]    quot_q, quot_d;
  total_t               rem_q, rem_d;
  total_t               div_q, div_d;
  logic [TOTAL_W:0]     trial;
  total_t               rem_step;

  // one shift-subtract step
  always_comb begin
    trial = {rem_q, quot_q[DRAW_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_step = TOTAL_W'(trial - {1'b0, div_q});
    end else begin
      rem_step = TOTAL_W'(trial);
    end
  end

  // step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DRAW_W);
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = rem_step;
      quot_d = {quot_q[DRAW_W-2:0], 1'b0};
      cnt_d  = DIV_CNT_W'(cnt_q - 1'b1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* design/lsch_seq.sv */
// -----------------------------------------------------------------------------
// Lottery scheduler sequencer
// Slot table and the state machine that walks it for commands and draws.
// -----------------------------------------------------------------------------
module lsch_seq import lsch_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsch_in_if.sink    in_i,
  lsch_out_if.source out_o,
  input  logic       dynamic_i,
  input  logic       alternate_i
);

  state_e                  state_q, state_d;
  cmd_e                    cmd_q, cmd_d;
  logic [SLOT_FIELD_W-1:0] slot_q, slot_d;
  logic [DRAW_W-1:0]       draw_q, draw_d;
  logic [SLOT_W-1:0]       idx_q, idx_d;
  total_t                  total_q, total_d;
  total_t                  left_q, left_d;
  logic                    found_q, found_d;
  logic [SLOT_W-1:0]       wslot_q, wslot_d;
  status_e                 status_q, status_d;
  logic                    wvalid_q, wvalid_d;

  // result register
  logic                     ov_q, ov_d;
  logic [STATUS_W-1:0]      o_status_q, o_status_d;
  logic                     o_wvalid_q, o_wvalid_d;
  logic [SLOT_FIELD_W-1:0]  o_wslot_q, o_wslot_d;
  logic [TOTAL_FIELD_W-1:0] o_total_q, o_total_d;

  // slot table
  ticket_t tix_q  [SLOTS];
  logic    act_q  [SLOTS];
  logic    mark_q [SLOTS];

  logic              wr_tix, wr_act, wr_mark;
  ticket_t           wr_tix_val;
  logic              wr_act_val, wr_mark_val;
  logic [SLOT_W-1:0] rd_addr;
  ticket_t           rd_tix;
  logic              rd_act;
  logic              in_range;
  logic              last_idx;
  total_t            sum;
  total_t            rd_tix_ext;

  logic   mod_start, mod_done;
  total_t mod_rem;

  // single table port: command slot in S_CMD, walk index otherwise
  assign rd_addr    = (state_q == S_CMD) ? SLOT_W'(slot_q) : idx_q;
  assign rd_tix     = tix_q[rd_addr];
  assign rd_act     = act_q[rd_addr];
  assign rd_tix_ext = TOTAL_W'(rd_tix);
  assign in_range   = (32'(slot_q) < SLOTS);
  assign last_idx   = (idx_q == SLOT_W'(SLOTS - 1));
  assign sum        = TOTAL_W'(total_q + (rd_act ? rd_tix_ext : '0));

  lsch_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (draw_q),
    .divisor_i  (sum),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    slot_d      = slot_q;
    draw_d      = draw_q;
    idx_d       = idx_q;
    total_d     = total_q;
    left_d      = left_q;
    found_d     = found_q;
    wslot_d     = wslot_q;
    status_d    = status_q;
    wvalid_d    = wvalid_q;
    ov_d        = ov_q && !out_o.ready;
    o_status_d  = o_status_q;
    o_wvalid_d  = o_wvalid_q;
    o_wslot_d   = o_wslot_q;
    o_total_d   = o_total_q;
    wr_tix      = 1'b0;
    wr_act      = 1'b0;
    wr_mark     = 1'b0;
    wr_tix_val  = rd_tix;
    wr_act_val  = rd_act;
    wr_mark_val = 1'b0;
    mod_start   = 1'b0;
    in_i.ready  = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d   = cmd_e'(in_i.cmd);
          slot_d  = in_i.slot;
          draw_d  = in_i.draw_value;
          state_d = S_CMD;
        end
      end

      S_CMD: begin
        status_d = ST_OK;
        wvalid_d = 1'b0;
        wslot_d  = '0;
        total_d  = '0;
        state_d  = S_OUT;
        unique case (cmd_q)
          CMD_START_SYS, CMD_START_INH: begin
            if (!in_range) begin
              status_d = ST_INACTIVE;
            end else begin
              wr_tix      = 1'b1;
              wr_act      = 1'b1;
              wr_mark     = 1'b1;
              wr_act_val  = 1'b1;
              wr_mark_val = 1'b0;
              wr_tix_val  = (cmd_q == CMD_START_SYS) ? ticket_t'(START_SYS_TICKETS)
                                                     : ticket_t'(START_INH_TICKETS);
            end
          end
          CMD_STOP: begin
            if (!in_range || !rd_act) begin
              status_d = ST_INACTIVE;
            end else begin
              wr_act      = 1'b1;
              wr_mark     = 1'b1;
              wr_act_val  = 1'b0;
              wr_mark_val = 1'b0;
            end
          end
          CMD_EXPIRE: begin
            if (!in_range || !rd_act) begin
              status_d = ST_INACTIVE;
            end else begin
              // dynamic mode takes one ticket from the expiring slot if it holds more than one
              if (dynamic_i && (rd_tix > ticket_t'(1))) begin
                wr_tix     = 1'b1;
                wr_tix_val = ticket_t'(rd_tix - 1'b1);
              end
              idx_d   = '0;
              state_d = S_SUM;
            end
          end
          default: begin
            status_d = ST_INACTIVE;
          end
        endcase
      end

      // first walk: total of active tickets
      S_SUM: begin
        total_d = sum;
        idx_d   = SLOT_W'(idx_q + 1'b1);
        if (last_idx) begin
          idx_d = '0;
          if (sum == '0) begin
            status_d = ST_NO_TICKETS;
            state_d  = S_OUT;
          end else begin
            mod_start = 1'b1;
            state_d   = S_MOD;
          end
        end
      end

      S_MOD: begin
        if (mod_done) begin
          left_d  = mod_rem;
          found_d = 1'b0;
          idx_d   = '0;
          state_d = S_DRAW;
        end
      end

      // second walk: pick the winner, reward every other active slot
      S_DRAW: begin
        if (rd_act) begin
          wr_tix  = 1'b1;
          wr_mark = 1'b1;
          if (!found_q && (left_q < rd_tix_ext)) begin
            found_d     = 1'b1;
            wvalid_d    = 1'b1;
            wslot_d     = idx_q;
            wr_mark_val = 1'b1;
            wr_tix_val  = alternate_i ? ticket_t'(rd_tix >> 1) : rd_tix;
          end else begin
            if (!found_q) begin
              left_d = TOTAL_W'(left_q - rd_tix_ext);
            end
            wr_mark_val = 1'b0;
            wr_tix_val  = grow_loser(rd_tix, alternate_i);
          end
        end
        idx_d = SLOT_W'(idx_q + 1'b1);
        if (last_idx) begin
          idx_d   = '0;
          state_d = S_OUT;
        end
      end

      // hand the result to the output register once it is free
      S_OUT: begin
        if (!ov_q || out_o.ready) begin
          ov_d       = 1'b1;
          o_status_d = status_q;
          o_wvalid_d = wvalid_q;
          o_wslot_d  = SLOT_FIELD_W'(wslot_q);
          o_total_d  = sat_total(total_q);
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    slot_q     <= slot_d;
    draw_q     <= draw_d;
    idx_q      <= idx_d;
    total_q    <= total_d;
    left_q     <= left_d;
    found_q    <= found_d;
    wslot_q    <= wslot_d;
    status_q   <= status_d;
    wvalid_q   <= wvalid_d;
    o_status_q <= o_status_d;
    o_wvalid_q <= o_wvalid_d;
    o_wslot_q  <= o_wslot_d;
    o_total_q  <= o_total_d;
  end

  // slot table, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tix_q[i]  <= '0;
        act_q[i]  <= 1'b0;
        mark_q[i] <= 1'b0;
      end
    end else begin
      if (wr_tix) begin
        tix_q[rd_addr] <= wr_tix_val;
      end
      if (wr_act) begin
        act_q[rd_addr] <= wr_act_val;
      end
      if (wr_mark) begin
        mark_q[rd_addr] <= wr_mark_val;
      end
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.status        = o_status_q;
  assign out_o.winner_valid  = o_wvalid_q;
  assign out_o.winner_slot   = o_wslot_q;
  assign out_o.total_tickets = o_total_q;

endmodule

/* design/lottery_scheduler.sv */
// -----------------------------------------------------------------------------
// Lottery scheduler
// Lottery arbiter over a table of process slots with start, stop and draw.
// -----------------------------------------------------------------------------
// Usage:
//   in_i carries one command item (cmd, slot, draw_value); out_o returns one
//   result item (status, winner_valid, winner_slot, total_tickets) for each.
//   cfg_i writes the mode bits: index 0 dynamic mode, index 1 alternate mode;
//   it is always ready and should only be written while no item is in flight.
// Operation:
//   start and stop items, and an expiry on an inactive slot, go from S_CMD
//   straight to S_OUT; an expiry that finds no tickets ends after the sum walk.
//   an expiry that draws makes one walk over the table to sum tickets, a
//   bit-serial modulo of DRAW_W steps, and a second walk that picks the winner
//   and updates every active slot, all through a single table port.
//   in_i.ready is high only while the sequencer is idle; one item at a time.
// Reset:
//   rst_ni clears all slots (inactive, zero tickets, no marks), both modes
//   and the result register's valid flag.
// Stalls:
//   a result waits in the output register while out_o.ready is low; the next
//   item is still accepted and its result is held in the sequencer until the
//   output register frees up.
// -----------------------------------------------------------------------------
module lottery_scheduler import lsch_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsch_in_if.sink    in_i,
  lsch_out_if.source out_o,
  lsch_cfg_if.sink   cfg_i
);

  logic dynamic_q, dynamic_d;
  logic alternate_q, alternate_d;

  // mode registers
  assign cfg_i.ready = 1'b1;

  always_comb begin
    dynamic_d   = dynamic_q;
    alternate_d = alternate_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_DYNAMIC:   dynamic_d   = cfg_i.data[0];
        CFG_ALTERNATE: alternate_d = cfg_i.data[0];
        default: begin
          dynamic_d   = dynamic_q;
          alternate_d = alternate_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dynamic_q   <= 1'b0;
      alternate_q <= 1'b0;
    end else begin
      dynamic_q   <= dynamic_d;
      alternate_q <= alternate_d;
    end
  end

  lsch_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .dynamic_i   (dynamic_q),
    .alternate_i (alternate_q)
  );

endmodule

/* design/lsch_checker.sv */
// -----------------------------------------------------------------------------
// Lottery scheduler checker
// Port-level assertions on the command and result channels.
// -----------------------------------------------------------------------------
module lsch_checker import lsch_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [STATUS_W-1:0]      out_status_i,
  input logic                     out_wvalid_i,
  input logic [SLOT_FIELD_W-1:0]  out_wslot_i,
  input logic [TOTAL_FIELD_W-1:0] out_total_i
);

  // one item at a time: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("command channel still ready after an accepted item");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_status_i)
      && $stable(out_wvalid_i) && $stable(out_wslot_i) && $stable(out_total_i)))
    else $error("stalled result item changed");

  // a winner needs an ok status and a nonzero pool
  a_winner_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_wvalid_i) |-> ((out_status_i == ST_OK) && (out_total_i != '0)))
    else $error("winner reported without tickets or with error status");

  // no winner means slot zero, and an empty pool reports a zero total
  a_no_winner_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_wvalid_i) |-> ((out_wslot_i == '0)
      && ((out_status_i != ST_NO_TICKETS) || (out_total_i == '0))))
    else $error("fields inconsistent on an item without a winner");

endmodule

bind lottery_scheduler lsch_checker u_lsch_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_wvalid_i (out_o.winner_valid),
  .out_wslot_i  (out_o.winner_slot),
  .out_total_i  (out_o.total_tickets)
);

/* tb/sv/tb_lottery_scheduler.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Lottery scheduler testbench
// Drives start, stop and expiry commands with random gaps and result stalls
// under every mode setting. A ticket table kept alongside the block predicts
// each result item, and every result is compared field by field in order.
// -----------------------------------------------------------------------------
module tb_lottery_scheduler;
  import lsch_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 126;
  localparam int TAIL_CYCLES = 60;
  localparam int HOLD_AFTER  = 150;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    status_e                  status;
    logic                     winner_valid;
    logic [SLOT_FIELD_W-1:0]  winner_slot;
    logic [TOTAL_FIELD_W-1:0] total_tickets;
  } outcome_t;

  // ticket table mirror and queue of predicted outcomes
  class ticket_board;
    ticket_t  tickets [SLOTS];
    logic     active  [SLOTS];
    logic     marked  [SLOTS];
    logic     dynamic_on;
    logic     alternate_on;
    outcome_t expected_q [$];
    int       errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        tickets[i] = '0;
        active[i]  = 1'b0;
        marked[i]  = 1'b0;
      end
      dynamic_on   = 1'b0;
      alternate_on = 1'b0;
      errors       = 0;
    endfunction

    // losers gain one ticket, two in alternate mode, up to the cap
    function ticket_t reward(ticket_t t);
      ticket_t v;
      v = t;
      if (v < TICKET_CAP) begin
        v++;
        if (alternate_on && v < TICKET_CAP) v++;
      end
      return v;
    endfunction

    function void note_mode(cfg_idx_e idx, logic val);
      case (idx)
        CFG_DYNAMIC:   dynamic_on = val;
        CFG_ALTERNATE: alternate_on = val;
        default: ;
      endcase
    endfunction

    // apply one accepted command to the table and queue its outcome
    function void note_command(cmd_e cmd, logic [SLOT_FIELD_W-1:0] slot,
                               logic [DRAW_W-1:0] draw);
      outcome_t o;
      int       s, total, left;
      bit       in_use, found;
      s      = int'(slot);
      in_use = (s < SLOTS) ? active[s] : 1'b0;
      total  = 0;
      o.status        = ST_OK;
      o.winner_valid  = 1'b0;
      o.winner_slot   = '0;
      case (cmd)
        CMD_START_SYS, CMD_START_INH: begin
          if (s >= SLOTS) begin
            o.status = ST_INACTIVE;
          end else begin
            active[s]  = 1'b1;
            marked[s]  = 1'b0;
            tickets[s] = (cmd == CMD_START_SYS) ? ticket_t'(START_SYS_TICKETS)
                                                : ticket_t'(START_INH_TICKETS);
          end
        end
        CMD_STOP: begin
          if (!in_use) begin
            o.status = ST_INACTIVE;
          end else begin
            active[s] = 1'b0;
            marked[s] = 1'b0;
          end
        end
        default: begin
          if (!in_use) begin
            o.status = ST_INACTIVE;
          end else begin
            if (dynamic_on && tickets[s] > 1) tickets[s]--;
            for (int i = 0; i < SLOTS; i++) begin
              if (active[i]) total += tickets[i];
            end
            if (total == 0) begin
              o.status = ST_NO_TICKETS;
            end else begin
              // running subtraction in slot order picks the winner
              left  = int'(draw) % total;
              found = 1'b0;
              for (int i = 0; i < SLOTS; i++) begin
                if (active[i]) begin
                  if (!found && left < tickets[i]) begin
                    found          = 1'b1;
                    o.winner_valid = 1'b1;
                    o.winner_slot  = SLOT_FIELD_W'(i);
                    marked[i]      = 1'b1;
                    if (alternate_on) tickets[i] = tickets[i] >> 1;
                  end else begin
                    if (!found) left -= tickets[i];
                    marked[i]  = 1'b0;
                    tickets[i] = reward(tickets[i]);
                  end
                end
              end
            end
          end
        end
      endcase
      o.total_tickets = (total > TOTAL_FIELD_MAX) ? TOTAL_FIELD_W'(TOTAL_FIELD_MAX)
                                                  : TOTAL_FIELD_W'(total);
      expected_q.push_back(o);
    endfunction

    // compare one result item with the oldest prediction
    function void check_result(outcome_t got);
      outcome_t want;
      if (expected_q.size() == 0) begin
        $error("result item with no command pending: status %0d", got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.winner_valid !== want.winner_valid) begin
        $error("winner_valid: expected %0d, actual %0d", want.winner_valid,
               got.winner_valid);
        errors++;
      end
      if (got.winner_slot !== want.winner_slot) begin
        $error("winner_slot: expected %0d, actual %0d", want.winner_slot,
               got.winner_slot);
        errors++;
      end
      if (got.total_tickets !== want.total_tickets) begin
        $error("total_tickets: expected %0d, actual %0d", want.total_tickets,
               got.total_tickets);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  int          cycle_count;
  int          results_seen;
  ticket_board board = new();

  lsch_in_if  cmd_ch ();
  lsch_out_if res_ch ();
  lsch_cfg_if mode_ch ();

  lottery_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch),
    .cfg_i  (mode_ch)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("lottery_scheduler: mismatch");
    $finish;
  end

  // result side: random stalls, one long hold-off to back up the block
  initial begin
    int       stall_left;
    int       r;
    bit       held;
    outcome_t got;
    stall_left   = 0;
    held         = 1'b0;
    results_seen = 0;
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && (cycle_count / 1000) % 4 != 0) begin
        r = $urandom_range(0, 99);
        if (r < 8) stall_left = $urandom_range(1, 3);
        else if (r < 10) stall_left = $urandom_range(20, 80);
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
      end
      @(posedge clk_i);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        got.status        = status_e'(res_ch.status);
        got.winner_valid  = res_ch.winner_valid;
        got.winner_slot   = res_ch.winner_slot;
        got.total_tickets = res_ch.total_tickets;
        board.check_result(got);
        results_seen++;
      end
    end
  end

  // sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // offer one command item after a gap and wait for its acceptance
  task automatic send_command(cmd_e c, logic [SLOT_FIELD_W-1:0] s,
                              logic [DRAW_W-1:0] d, int gap);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.cmd        <= c;
    cmd_ch.slot       <= s;
    cmd_ch.draw_value <= d;
    @(posedge clk_i);
    while (cmd_ch.ready !== 1'b1) @(posedge clk_i);
    board.note_command(c, s, d);
  endtask

  // register write on the mode channel
  task automatic write_mode(cfg_idx_e idx, logic val);
    mode_ch.valid <= 1'b1;
    mode_ch.index <= idx;
    mode_ch.data  <= val;
    @(posedge clk_i);
    while (mode_ch.ready !== 1'b1) @(posedge clk_i);
    board.note_mode(idx, val);
    mode_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering and wait for every predicted result
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // random commands, biased toward expiries so the tickets move
  task automatic random_phase(int count, bit calm);
    int                      r;
    cmd_e                    c;
    logic [SLOT_FIELD_W-1:0] s;
    logic [DRAW_W-1:0]       d;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 48) c = CMD_EXPIRE;
      else if (r < 68) c = CMD_START_SYS;
      else if (r < 84) c = CMD_START_INH;
      else c = CMD_STOP;
      s = SLOT_FIELD_W'($urandom_range(0, 15));
      r = $urandom_range(0, 9);
      if (r == 0) d = '0;
      else if (r == 1) d = '1;
      else d = DRAW_W'($urandom);
      send_command(c, s, d, calm ? 0 : pick_gap());
    end
  endtask

  // main sequence
  initial begin
    cmd_ch.valid      <= 1'b0;
    cmd_ch.cmd        <= CMD_START_SYS;
    cmd_ch.slot       <= '0;
    cmd_ch.draw_value <= '0;
    mode_ch.valid     <= 1'b0;
    mode_ch.index     <= CFG_DYNAMIC;
    mode_ch.data      <= 1'b0;
    rst_ni            <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: alternate mode drives a lone slot down to zero tickets
    write_mode(CFG_DYNAMIC, 1'b0);
    write_mode(CFG_ALTERNATE, 1'b1);
    send_command(CMD_EXPIRE, 4'd0, 16'hFFFF, 0);    // expiry with nothing active
    send_command(CMD_STOP, 4'd5, 16'h0000, 0);      // stop on inactive slot
    send_command(CMD_START_INH, 4'd3, 16'h0000, 0);
    send_command(CMD_EXPIRE, 4'd3, 16'hFFFF, 0);
    send_command(CMD_EXPIRE, 4'd3, 16'h0000, 2);
    send_command(CMD_EXPIRE, 4'd3, 16'h1234, 0);
    send_command(CMD_EXPIRE, 4'd3, 16'hA5A5, 0);    // zero total, no draw
    send_command(CMD_START_SYS, 4'd0, 16'h0000, 0);
    send_command(CMD_EXPIRE, 4'd0, 16'h0000, 0);    // zero-ticket slot gains as loser
    send_command(CMD_START_SYS, 4'd15, 16'hFFFF, 5);
    send_command(CMD_START_SYS, 4'd15, 16'h5A5A, 0); // restart of an active slot
    send_command(CMD_EXPIRE, 4'd15, 16'hFFFF, 0);
    send_command(CMD_EXPIRE, 4'd3, 16'h0007, 0);
    send_command(CMD_STOP, 4'd0, 16'h0000, 0);
    send_command(CMD_STOP, 4'd0, 16'h0000, 0);      // second stop finds it inactive
    send_command(CMD_EXPIRE, 4'd0, 16'hFFFF, 0);    // expiry on stopped slot
    send_command(CMD_START_INH, 4'd0, 16'hFFFF, 1);
    send_command(CMD_EXPIRE, 4'd15, 16'h8000, 0);

    // random phases across all mode settings
    for (int p = 0; p < 5; p++) begin
      drain();
      write_mode(CFG_DYNAMIC, p[0]);
      write_mode(CFG_ALTERNATE, p[1]);
      random_phase(PHASE_ITEMS, p == 2);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("lottery_scheduler: match");
    end else begin
      $display("lottery_scheduler: mismatch");
    end
    $finish;
  end

endmodule

/* lottery_scheduler.f */
design/lsch_pkg.sv
design/lsch_if.sv
design/lsch_mod.sv
design/lsch_seq.sv
design/lottery_scheduler.sv
design/lsch_checker.sv
tb/sv/tb_lottery_scheduler.sv
